FILE: rtl/vmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, widths and constants for the vec4 matrix transform unit.
// No dependencies; every other file imports this package.
package vmt_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_BITS  = 32;
  localparam int FIELD_BITS = 32;
  localparam int DIM        = 4;
  localparam int IDX_BITS   = 2;
  localparam int PROD_BITS  = 2 * WORD_BITS;
  localparam int SUM_BITS   = PROD_BITS + 2;

  typedef logic signed [FIELD_BITS-1:0] field_t;
  typedef logic signed [WORD_BITS-1:0]  word_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic [IDX_BITS-1:0]          idx_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_t;

  // Word range limits, as words and sign-extended to the sum width
  localparam word_t WORD_MAX_W = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam word_t WORD_MIN_W = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});
  localparam sum_t  SAT_HI     = sum_t'(WORD_MAX_W);
  localparam sum_t  SAT_LO     = sum_t'(WORD_MIN_W);

  // Reset value of the diagonal: 1.0, clipped to the largest word
  localparam word_t ONE_VAL = (FRAC_BITS >= WORD_BITS - 1) ? WORD_MAX_W
                                                           : (word_t'(1) << FRAC_BITS);

  // Stage load enables handed from the top level to the column datapaths
  typedef struct packed {
    logic ld_mul;
    logic ld_add1;
    logic ld_add2;
    logic ld_sat;
  } vmt_adv_t;

  // Take the low word of a field, sign-extended
  function automatic word_t to_word(input field_t f);
    return word_t'(f[WORD_BITS-1:0]);
  endfunction

  // Sign-extend a word back to the field width
  function automatic field_t to_field(input word_t w);
    return field_t'(w);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/vmt_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Input channel of the transform unit: valid/ready plus one item.
// Depends on vmt_pkg for field types.
interface vmt_in_if
  import vmt_pkg::*;
;
  logic   valid;
  logic   ready;
  logic   op;
  idx_t   row;
  idx_t   col;
  field_t coeff;
  field_t vec_x;
  field_t vec_y;
  field_t vec_z;
  field_t vec_w;

  modport source (output valid, op, row, col, coeff, vec_x, vec_y, vec_z, vec_w,
                  input ready);
  modport sink   (input valid, op, row, col, coeff, vec_x, vec_y, vec_z, vec_w,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/vmt_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Output channel of the transform unit: valid/ready plus one result item.
// Depends on vmt_pkg for field types.
interface vmt_out_if
  import vmt_pkg::*;
;
  logic   valid;
  logic   ready;
  field_t out_x;
  field_t out_y;
  field_t out_z;
  field_t out_w;
  logic   saturated;

  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface
`default_nettype wire

FILE: rtl/vmt_column.sv
`timescale 1ns / 1ps
`default_nettype none
// One output component: four multipliers, a two-level adder tree, then
// shift and saturate. Four register stages; depends on vmt_pkg.
module vmt_column
  import vmt_pkg::*;
(
  input  wire logic     clk,
  input  wire vmt_adv_t adv,
  input  wire word_t    coef [DIM],
  input  wire word_t    vec  [DIM],
  output field_t        result,
  output logic          clip
);

  prod_t prod [DIM];
  sum_t  pair [2];
  sum_t  total;
  sum_t  shifted;

  // Stage 1: one full product per row
  always_ff @(posedge clk) begin
    if (adv.ld_mul) begin
      for (int i = 0; i < DIM; i++) begin
        prod[i] <= prod_t'(coef[i]) * prod_t'(vec[i]);
      end
    end
  end

  // Stage 2: add products in pairs
  always_ff @(posedge clk) begin
    if (adv.ld_add1) begin
      pair[0] <= sum_t'(prod[0]) + sum_t'(prod[1]);
      pair[1] <= sum_t'(prod[2]) + sum_t'(prod[3]);
    end
  end

  // Stage 3: exact four-term sum
  always_ff @(posedge clk) begin
    if (adv.ld_add2) begin
      total <= pair[0] + pair[1];
    end
  end

  // Drop the fraction bits, rounding toward minus infinity
  assign shifted = total >>> FRAC_BITS;

  // Stage 4: clip to the word range and flag it
  always_ff @(posedge clk) begin
    if (adv.ld_sat) begin
      if (shifted > SAT_HI) begin
        result <= to_field(WORD_MAX_W);
        clip   <= 1'b1;
      end else if (shifted < SAT_LO) begin
        result <= to_field(WORD_MIN_W);
        clip   <= 1'b1;
      end else begin
        result <= to_field(word_t'(shifted[WORD_BITS-1:0]));
        clip   <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vec4_matrix_transform_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Vertex transform unit: 4x4 matrix store times 4-vector, signed fixed point.
// A transform item passes the multiplier, adder and saturation registers in order.
// Throughput: one item per cycle while the output is not stalled; four register
// stages set by the multipliers, the two adder levels and the saturation stage.
// Reset (synchronous, rst high) empties the pipeline and sets the matrix to identity.
// Depends on vmt_pkg, vmt_in_if, vmt_out_if and vmt_column.
module vec4_matrix_transform_unit
  import vmt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  vmt_in_if.sink    in_ch,
  vmt_out_if.source out_ch
);

  word_t    mat [DIM][DIM];
  word_t    vec [DIM];
  word_t    col_coef [DIM][DIM];
  field_t   col_res [DIM];
  logic     col_clip [DIM];
  logic     v1, v2, v3, v4;
  vmt_adv_t adv;
  logic     acc;

  // Each stage loads when empty or when its content moves on
  always_comb begin
    adv.ld_sat  = ~v4 | out_ch.ready;
    adv.ld_add2 = ~v3 | adv.ld_sat;
    adv.ld_add1 = ~v2 | adv.ld_add2;
    adv.ld_mul  = ~v1 | adv.ld_add1;
  end

  assign in_ch.ready = adv.ld_mul;
  assign acc         = in_ch.valid & in_ch.ready;

  // Advance valid bits with the data; only transform items enter
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv.ld_mul)  v1 <= acc & (in_ch.op == OP_XFORM);
      if (adv.ld_add1) v2 <= v1;
      if (adv.ld_add2) v3 <= v2;
      if (adv.ld_sat)  v4 <= v3;
    end
  end

  // Matrix store: identity after reset, one element per load item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          mat[r][c] <= (r == c) ? ONE_VAL : '0;
        end
      end
    end else if (acc && in_ch.op == OP_LOAD) begin
      mat[in_ch.row][in_ch.col] <= to_word(in_ch.coeff);
    end
  end

  assign vec[0] = to_word(in_ch.vec_x);
  assign vec[1] = to_word(in_ch.vec_y);
  assign vec[2] = to_word(in_ch.vec_z);
  assign vec[3] = to_word(in_ch.vec_w);

  // Output j takes column j of the matrix
  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      for (int i = 0; i < DIM; i++) begin
        col_coef[j][i] = mat[i][j];
      end
    end
  end

  for (genvar j = 0; j < DIM; j++) begin : g_col
    vmt_column u_col (
      .clk    (clk),
      .adv    (adv),
      .coef   (col_coef[j]),
      .vec    (vec),
      .result (col_res[j]),
      .clip   (col_clip[j])
    );
  end

  assign out_ch.valid     = v4;
  assign out_ch.out_x     = col_res[0];
  assign out_ch.out_y     = col_res[1];
  assign out_ch.out_z     = col_res[2];
  assign out_ch.out_w     = col_res[3];
  assign out_ch.saturated = col_clip[0] | col_clip[1] | col_clip[2] | col_clip[3];

endmodule
`default_nettype wire

FILE: rtl/vmt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the transform unit, bound to the top level.
// Depends on vmt_pkg and vec4_matrix_transform_unit.
module vmt_checker
  import vmt_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   in_valid,
  input wire logic   in_ready,
  input wire logic   in_op,
  input wire logic   out_valid,
  input wire logic   out_ready,
  input wire field_t out_x,
  input wire field_t out_y,
  input wire field_t out_z,
  input wire field_t out_w,
  input wire logic   saturated
);

  logic   xform_acc;
  field_t f_max;
  field_t f_min;

  assign xform_acc = in_valid & in_ready & (in_op == OP_XFORM);
  assign f_max     = to_field(WORD_MAX_W);
  assign f_min     = to_field(WORD_MIN_W);

  // Hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item present after reset");

  // An accepted transform can be taken at the output when nothing stalls
  a_latency: assert property (@(posedge clk) disable iff (rst)
    xform_acc ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("transform item late at the output");

  // A clipped result shows a limit value in at least one component
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (out_x == f_max || out_x == f_min || out_y == f_max || out_y == f_min ||
       out_z == f_max || out_z == f_min || out_w == f_max || out_w == f_min))
    else $error("saturated flag without a limit value");

endmodule

bind vec4_matrix_transform_unit vmt_checker u_vmt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.out_x),
  .out_y     (out_ch.out_y),
  .out_z     (out_ch.out_z),
  .out_w     (out_ch.out_w),
  .saturated (out_ch.saturated)
);
`default_nettype wire
